// ===== hdl/expl_pkg.sv =====
package expl_pkg;

  localparam int NUMBER_BITS = 32;
  localparam int TOKEN_BITS  = 32;
  localparam int KW_LEN      = 5;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [3:0] {
    TK_NUMBER = 4'd0,
    TK_IDENT  = 4'd1,
    TK_PRINT  = 4'd2,
    TK_SCHAR  = 4'd3,
    TK_SEND   = 4'd4,
    TK_PLUS   = 4'd5,
    TK_MINUS  = 4'd6,
    TK_MUL    = 4'd7,
    TK_DIV    = 4'd8,
    TK_LPAREN = 4'd9,
    TK_RPAREN = 4'd10,
    TK_ASSIGN = 4'd11,
    TK_END    = 4'd12,
    TK_ERROR  = 4'd13
  } tok_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NUM  = 3'd1,
    MODE_WORD = 3'd2,
    MODE_STR  = 3'd3,
    MODE_ERR  = 3'd4
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    tok_kind_t               token_kind;
    logic [TOKEN_BITS-1:0]   token_value;
    logic                    last_of_run;
  } out_item_t;

  // results of one accepted item, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } res_pair_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h70;  // p
      3'd1:    ch = 8'h72;  // r
      3'd2:    ch = 8'h69;  // i
      3'd3:    ch = 8'h6e;  // n
      3'd4:    ch = 8'h74;  // t
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // single-byte operator lookup; anything else maps to error
  function automatic tok_kind_t op_kind(logic [7:0] c);
    tok_kind_t k;
    case (c)
      CH_PLUS:   k = TK_PLUS;
      CH_MINUS:  k = TK_MINUS;
      CH_STAR:   k = TK_MUL;
      CH_SLASH:  k = TK_DIV;
      CH_LPAREN: k = TK_LPAREN;
      CH_RPAREN: k = TK_RPAREN;
      CH_EQUAL:  k = TK_ASSIGN;
      default:   k = TK_ERROR;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/expl_core.sv =====
module expl_core import expl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_acc,
  input  in_item_t  in_item,
  output res_pair_t res
);

  lex_mode_t              mode_r, mode_nxt;
  logic [NUMBER_BITS-1:0] acc_r, acc_nxt;
  logic [2:0]             kpos_r, kpos_nxt;
  logic                   kmatch_r, kmatch_nxt;

  logic [7:0]       c;
  logic             eot;
  logic             first_v, second_v, go_idle;
  tok_kind_t        first_k, second_k;
  logic [TOKEN_BITS-1:0] first_val;
  logic             id_emit;
  tok_kind_t        id_kind;
  lex_mode_t        id_mode;
  logic             kw_hit;
  tok_kind_t        word_k;
  out_item_t        first_item, second_item;

  assign c   = in_item.char_byte;
  assign eot = in_item.end_of_text;

  assign kw_hit = kmatch_r && (kpos_r < 3'(KW_LEN)) && (c == kw_char(kpos_r));
  assign word_k = (kmatch_r && (kpos_r == 3'(KW_LEN))) ? TK_PRINT : TK_IDENT;

  // what a byte does when lexed from the idle mode
  always_comb begin
    id_emit = 1'b0;
    id_kind = TK_ERROR;
    id_mode = MODE_IDLE;
    if (is_space(c)) begin
      id_mode = MODE_IDLE;
    end else if (is_digit(c)) begin
      id_mode = MODE_NUM;
    end else if (is_alpha(c)) begin
      id_mode = MODE_WORD;
    end else if (c == CH_QUOTE) begin
      id_mode = MODE_STR;
    end else begin
      id_emit = 1'b1;
      id_kind = op_kind(c);
      id_mode = (id_kind == TK_ERROR) ? MODE_ERR : MODE_IDLE;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    acc_nxt    = acc_r;
    kpos_nxt   = kpos_r;
    kmatch_nxt = kmatch_r;
    first_v    = 1'b0;
    first_k    = TK_END;
    first_val  = '0;
    second_v   = 1'b0;
    second_k   = TK_END;
    go_idle    = 1'b0;

    if (eot) begin
      case (mode_r)
        MODE_NUM: begin
          first_v   = 1'b1;
          first_k   = TK_NUMBER;
          first_val = TOKEN_BITS'(acc_r);
        end
        MODE_WORD: begin
          first_v = 1'b1;
          first_k = word_k;
        end
        MODE_STR: begin
          first_v = 1'b1;
          first_k = TK_SEND;
        end
        default: first_v = 1'b0;
      endcase
      second_v   = 1'b1;
      second_k   = TK_END;
      mode_nxt   = MODE_IDLE;
      acc_nxt    = '0;
      kpos_nxt   = '0;
      kmatch_nxt = 1'b1;
    end else begin
      case (mode_r)
        MODE_ERR: mode_nxt = MODE_ERR;
        MODE_NUM: begin
          if (is_digit(c)) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + NUMBER_BITS'(c[3:0]);
          end else begin
            first_v   = 1'b1;
            first_k   = TK_NUMBER;
            first_val = TOKEN_BITS'(acc_r);
            acc_nxt   = '0;
            go_idle   = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (kw_hit) begin
              kpos_nxt = kpos_r + 3'd1;
            end else begin
              kmatch_nxt = 1'b0;
            end
          end else begin
            first_v    = 1'b1;
            first_k    = word_k;
            kpos_nxt   = '0;
            kmatch_nxt = 1'b1;
            go_idle    = 1'b1;
          end
        end
        MODE_STR: begin
          first_v = 1'b1;
          if (c == CH_QUOTE) begin
            first_k  = TK_SEND;
            mode_nxt = MODE_IDLE;
          end else if (c == CH_NUL) begin
            // abandon the string, no string_end
            first_k  = TK_ERROR;
            mode_nxt = MODE_ERR;
          end else begin
            first_k   = TK_SCHAR;
            first_val = TOKEN_BITS'(c);
          end
        end
        default: go_idle = 1'b1;
      endcase

      if (go_idle) begin
        mode_nxt = id_mode;
        second_v = id_emit;
        second_k = id_kind;
        if (is_digit(c)) begin
          acc_nxt = NUMBER_BITS'(c[3:0]);
        end
        if (is_alpha(c)) begin
          kmatch_nxt = (c == kw_char(3'd0));
          kpos_nxt   = (c == kw_char(3'd0)) ? 3'd1 : 3'd0;
        end
      end
    end
  end

  always_comb begin
    first_item.token_kind   = first_k;
    first_item.token_value  = first_val;
    first_item.last_of_run  = !second_v;
    second_item.token_kind  = second_k;
    second_item.token_value = '0;
    second_item.last_of_run = 1'b1;

    res.cnt = 2'(first_v) + 2'(second_v);
    res.r0  = first_v ? first_item : second_item;
    res.r1  = second_item;
    if (!in_acc) begin
      res.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      acc_r    <= '0;
      kpos_r   <= '0;
      kmatch_r <= 1'b1;
    end else if (in_acc) begin
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      kpos_r   <= kpos_nxt;
      kmatch_r <= kmatch_nxt;
    end
  end

  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && eot |=> mode_r == MODE_IDLE && acc_r == '0 && kmatch_r)
    else $error("end item did not return lexer to reset state");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !eot && mode_r == MODE_ERR |-> res.cnt == 2'd0)
    else $error("result emitted in error mode");

  a_kw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kpos_r <= 3'(KW_LEN))
    else $error("keyword position out of range");

endmodule

// ===== hdl/expl_queue.sv =====
module expl_queue import expl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_pair_t res,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  out_item_t          q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               pop;

  // keep room for the two results one item can make
  assign in_stall  = (count_r > Q_CNT_W'(Q_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_item  = q_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(res.cnt);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(pop);
    count_nxt  = count_r + Q_CNT_W'(res.cnt) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (res.cnt != 2'd0) begin
      q_mem[wr_ptr_r] <= res.r0;
    end
    if (res.cnt == 2'd2) begin
      q_mem[wr_ptr_r + Q_PTR_W'(1)] <= res.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    Q_PTR_W'(wr_ptr_r - rd_ptr_r) == Q_PTR_W'(count_r))
    else $error("queue pointers disagree with count");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.cnt != 2'd0 |-> count_r + Q_CNT_W'(res.cnt) - Q_CNT_W'(pop)
                        <= Q_CNT_W'(Q_DEPTH))
    else $error("push into full queue");

endmodule

// ===== hdl/expression_lexer.sv =====
// channel   handshake               payload
// -------   ---------------------   -------------------------------------
// input     in_valid / in_stall     in_item  : char_byte, end_of_text
// result    out_valid / out_stall   out_item : token_kind, token_value,
//                                              last_of_run
//
// Each item is lexed in the cycle it is accepted; its results land in a
// four-entry result queue and appear at out_item in the next cycle at the earliest.
// One item per cycle while items make at most one result and out_stall stays low;
// the results of an item making two leave one at a time through the single result port.
// in_stall is high while the queue holds more than two results.
// Reset (rst_n low, synchronous) returns the lexer to idle and empties the queue.
module expression_lexer import expl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      in_acc;
  res_pair_t res;

  assign in_acc = in_valid && !in_stall;

  expl_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_item (in_item),
    .res     (res)
  );

  expl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
